FILE: rtl/shfp_pkg.sv
// Shared types and constants for the sync-header frame parser.
package shfp_pkg;

    // Sync header bytes and endianness selector ids
    localparam logic [7:0] HEAD_FIRST       = 8'h55;
    localparam logic [7:0] HEAD_SECOND      = 8'hAA;
    localparam logic [7:0] ID_BIG_ENDIAN    = 8'hFF;
    localparam logic [7:0] ID_LITTLE_ENDIAN = 8'hFE;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_BITS = 1;
    localparam int unsigned CFG_DATA_BITS = 16;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ID_LIMIT    = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_PAYLOAD = 1'd1;

    // Register reset values
    localparam logic [7:0]  ID_LIMIT_RESET    = 8'd16;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;

    // Parser phase
    typedef enum logic [2:0] {
        PH_HEAD1  = 3'd0,
        PH_HEAD2  = 3'd1,
        PH_ID     = 3'd2,
        PH_LENGTH = 3'd3,
        PH_DATA   = 3'd4
    } t_phase;

    // Result kind
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_LEN_ERR = 2'd2
    } t_kind;

    // One result item
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  frame_id;
        logic [15:0] frame_length;
        logic [15:0] byte_index;
        logic [7:0]  data_byte;
        logic        last;
    } t_result;

endpackage

FILE: rtl/shfp_parser.sv
// Per-byte frame parser state, configuration registers and result decode.
module shfp_parser
    import shfp_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    input  logic                     i_step,
    input  logic [7:0]               i_rx_byte,
    output logic                     o_res_valid,
    output t_result                  o_res
);

    localparam int unsigned CNT_BITS = LENGTH_BITS + 1;

    logic [7:0]             r_id_limit;
    logic [15:0]            r_max_len;
    t_phase                 r_phase, n_phase;
    logic                   r_big, n_big;
    logic [7:0]             r_id, n_id;
    logic [7:0]             r_first, n_first;
    logic                   r_seen, n_seen;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic [LENGTH_BITS-1:0] r_count, n_count;

    logic [15:0]            len_word;
    logic [LENGTH_BITS-1:0] len_new;
    logic [CNT_BITS-1:0]    count_next;
    logic                   data_end;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_limit <= ID_LIMIT_RESET;
            r_max_len  <= MAX_PAYLOAD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_ID_LIMIT:    r_id_limit <= i_cfg_wdata[7:0];
                CFG_MAX_PAYLOAD: r_max_len  <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Length assembly from the received byte and the stored first byte
    always_comb begin
        if (LENGTH_BITS > 8) begin
            len_word = r_big ? {r_first, i_rx_byte} : {i_rx_byte, r_first};
        end else begin
            len_word = {8'h00, i_rx_byte};
        end
        len_new    = len_word[LENGTH_BITS-1:0];
        count_next = CNT_BITS'(r_count) + CNT_BITS'(1);
        data_end   = count_next >= CNT_BITS'(r_len);
    end

    // Next state and result
    always_comb begin
        n_phase = r_phase;
        n_big   = r_big;
        n_id    = r_id;
        n_first = r_first;
        n_seen  = r_seen;
        n_len   = r_len;
        n_count = r_count;

        o_res_valid        = 1'b0;
        o_res.kind         = KIND_PAYLOAD;
        o_res.frame_id     = r_id;
        o_res.frame_length = 16'(r_len);
        o_res.byte_index   = 16'h0000;
        o_res.data_byte    = 8'h00;
        o_res.last         = 1'b1;

        case (r_phase)
            PH_HEAD2: begin
                n_phase = (i_rx_byte == HEAD_SECOND) ? PH_ID : PH_HEAD1;
            end
            PH_ID: begin
                n_id = i_rx_byte;
                if (i_rx_byte == ID_BIG_ENDIAN) begin
                    n_big   = 1'b1;
                    n_phase = PH_HEAD1;
                end else if (i_rx_byte == ID_LITTLE_ENDIAN) begin
                    n_big   = 1'b0;
                    n_phase = PH_HEAD1;
                end else if (i_rx_byte < r_id_limit) begin
                    n_seen  = 1'b0;
                    n_phase = PH_LENGTH;
                end else begin
                    n_phase = PH_HEAD1;
                end
            end
            PH_LENGTH: begin
                if (LENGTH_BITS > 8 && !r_seen) begin
                    n_first = i_rx_byte;
                    n_seen  = 1'b1;
                end else begin
                    n_len              = len_new;
                    n_seen             = 1'b0;
                    n_count            = '0;
                    o_res.frame_length = 16'(len_new);
                    if (16'(len_new) > r_max_len) begin
                        n_phase     = PH_HEAD1;
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_LEN_ERR;
                    end else if (len_new == '0) begin
                        n_phase     = PH_HEAD1;
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_EMPTY;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                o_res_valid      = 1'b1;
                o_res.kind       = KIND_PAYLOAD;
                o_res.byte_index = 16'(r_count);
                o_res.data_byte  = i_rx_byte;
                o_res.last       = data_end;
                if (data_end) begin
                    n_phase = PH_HEAD1;
                    n_count = '0;
                end else begin
                    n_count = count_next[LENGTH_BITS-1:0];
                end
            end
            default: begin
                // hunt for the first header byte
                n_phase = (i_rx_byte == HEAD_FIRST) ? PH_HEAD2 : PH_HEAD1;
            end
        endcase
    end

    // Parser state, advanced once per accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEAD1;
            r_big   <= 1'b0;
            r_id    <= 8'h00;
            r_first <= 8'h00;
            r_seen  <= 1'b0;
            r_len   <= '0;
            r_count <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_big   <= n_big;
            r_id    <= n_id;
            r_first <= n_first;
            r_seen  <= n_seen;
            r_len   <= n_len;
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    // the byte counter stays inside the frame while payload is flowing
    a_count_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_count < r_len)
        else $error("payload counter outside frame length");

    // a result that ends the frame sends the parser back to the hunt
    a_last_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res_valid && o_res.last) |=> r_phase == PH_HEAD1)
        else $error("parser did not return to hunt after frame end");

    // results only come out of the length or payload phases
    a_result_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (r_phase == PH_LENGTH || r_phase == PH_DATA))
        else $error("result outside length or payload phase");

    // a payload transfer consumes the counter in order
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase == PH_DATA && !data_end) |=> r_count == $past(r_count) + 1'b1)
        else $error("payload counter skipped");
`endif

endmodule

FILE: rtl/shfp_out_reg.sv
// Result register that holds one item until the downstream side takes it.
module shfp_out_reg
    import shfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_out_ready,
    output logic    o_can_load,
    output logic    o_out_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    // room when empty or when the held item leaves this cycle
    assign o_can_load  = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_res       = r_res;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

`ifndef SYNTHESIS
    // never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!r_valid || i_out_ready))
        else $error("result overwritten before transfer");

    // a load is always visible on the next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> (r_valid && r_res == $past(i_res)))
        else $error("loaded result not presented");

    // a held result with no take stays valid
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_out_ready) |=> r_valid)
        else $error("waiting result dropped");
`endif

endmodule

FILE: rtl/sync_header_frame_parser_core.sv
// Top level of the sync-header frame parser: parser state plus result register.
//
//   channel  | signals                                   | dir
//   ---------+-------------------------------------------+-----
//   input    | i_in_valid, o_in_ready, i_rx_byte         | in
//   result   | o_out_valid, i_out_ready, o_kind ... last | out
//   config   | i_cfg_we, i_cfg_addr, i_cfg_wdata         | in
//
// One byte is taken per cycle while the result register has room; its result,
// if any, appears in the next cycle from the result register.
// A stalled result blocks input only while the result register is full and
// not being taken. Reset is synchronous and returns the parser to the hunt
// with the configuration registers at their defaults.
module sync_header_frame_parser_core
    import shfp_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [7:0]               i_rx_byte,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [1:0]               o_kind,
    output logic [7:0]               o_frame_id,
    output logic [15:0]              o_frame_length,
    output logic [15:0]              o_byte_index,
    output logic [7:0]               o_data_byte,
    output logic                     o_last
);

    logic    step;
    logic    res_valid;
    logic    can_load;
    t_result res;
    t_result out_res;

    // a byte transfer happens when a byte is offered and the result register has room
    assign o_in_ready = can_load;
    assign step       = i_in_valid && can_load;

    shfp_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (step),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    shfp_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (step && res_valid),
        .i_res       (res),
        .i_out_ready (i_out_ready),
        .o_can_load  (can_load),
        .o_out_valid (o_out_valid),
        .o_res       (out_res)
    );

    // result fields
    assign o_kind         = out_res.kind;
    assign o_frame_id     = out_res.frame_id;
    assign o_frame_length = out_res.frame_length;
    assign o_byte_index   = out_res.byte_index;
    assign o_data_byte    = out_res.data_byte;
    assign o_last         = out_res.last;

endmodule

FILE: bench/sync_header_frame_parser_core_test.sv
// Self-checking bench for the sync-header frame parser: random traffic, live prediction.
`timescale 1ns / 100ps

module sync_header_frame_parser_core_test;
    import shfp_pkg::*;

    localparam int unsigned IDLE_LIMIT   = 1000;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned PHASE_BYTES  = 105;
    localparam int unsigned NUM_PHASES   = 8;

    // DUT signals, all inputs known from time zero
    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_addr  = CFG_ID_LIMIT;
    logic [CFG_DATA_BITS-1:0] i_cfg_wdata = '0;
    logic                     i_in_valid  = 1'b0;
    logic                     o_in_ready;
    logic [7:0]               i_rx_byte   = 8'h00;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic [1:0]               o_kind;
    logic [7:0]               o_frame_id;
    logic [15:0]              o_frame_length;
    logic [15:0]              o_byte_index;
    logic [7:0]               o_data_byte;
    logic                     o_last;

    sync_header_frame_parser_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_frame_id     (o_frame_id),
        .o_frame_length (o_frame_length),
        .o_byte_index   (o_byte_index),
        .o_data_byte    (o_data_byte),
        .o_last         (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Bench bookkeeping
    logic [7:0]  rx_pending [$];
    t_result     pending_results [$];
    int unsigned queued_bytes   = 0;
    int unsigned accepted_bytes = 0;
    int unsigned error_count    = 0;
    int unsigned idle_cycles    = 0;
    int unsigned send_gap       = 0;
    int unsigned stall_left     = 0;
    bit          in_xfer        = 1'b0;
    bit          out_xfer       = 1'b0;
    bit          steady_flow    = 1'b0;

    // Generator's view of the configuration and length byte order
    int unsigned gen_id_limit = 32'(ID_LIMIT_RESET);
    int unsigned gen_max_len  = 32'(MAX_PAYLOAD_RESET);
    bit          gen_big      = 1'b0;

    // Predictor state and configuration copy
    t_phase      rx_phase;
    logic        big_len;
    logic [7:0]  cur_id;
    logic [7:0]  first_len;
    logic        len_seen;
    logic [15:0] pay_len;
    logic [15:0] pay_cnt;
    logic [7:0]  lim_id;
    logic [15:0] lim_len;

    t_result     got_r;
    t_result     want_r;
    t_result     new_r;

    // Mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Advance the parser copy by one byte; returns 1 when a result is produced
    function automatic bit parse_rx_byte(input logic [7:0] b, output t_result res);
        bit produced;
        produced = 1'b0;
        res = '0;
        case (rx_phase)
            PH_HEAD2: rx_phase = (b == HEAD_SECOND) ? PH_ID : PH_HEAD1;
            PH_ID: begin
                cur_id = b;
                if (b == ID_BIG_ENDIAN) begin
                    big_len  = 1'b1;
                    rx_phase = PH_HEAD1;
                end else if (b == ID_LITTLE_ENDIAN) begin
                    big_len  = 1'b0;
                    rx_phase = PH_HEAD1;
                end else if (b < lim_id) begin
                    len_seen = 1'b0;
                    rx_phase = PH_LENGTH;
                end else begin
                    rx_phase = PH_HEAD1;
                end
            end
            PH_LENGTH: begin
                if (!len_seen) begin
                    first_len = b;
                    len_seen  = 1'b1;
                end else begin
                    pay_len  = big_len ? {first_len, b} : {b, first_len};
                    len_seen = 1'b0;
                    pay_cnt  = '0;
                    if (pay_len > lim_len) begin
                        rx_phase = PH_HEAD1;
                        res.kind = KIND_LEN_ERR;
                        res.last = 1'b1;
                        produced = 1'b1;
                    end else if (pay_len == 16'd0) begin
                        rx_phase = PH_HEAD1;
                        res.kind = KIND_EMPTY;
                        res.last = 1'b1;
                        produced = 1'b1;
                    end else begin
                        rx_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                res.kind       = KIND_PAYLOAD;
                res.byte_index = pay_cnt;
                res.data_byte  = b;
                res.last       = (({1'b0, pay_cnt} + 17'd1) >= {1'b0, pay_len});
                produced       = 1'b1;
                if (res.last) begin
                    rx_phase = PH_HEAD1;
                    pay_cnt  = '0;
                end else begin
                    pay_cnt = pay_cnt + 16'd1;
                end
            end
            default: rx_phase = (b == HEAD_FIRST) ? PH_HEAD2 : PH_HEAD1;
        endcase
        res.frame_id     = cur_id;
        res.frame_length = pay_len;
        return produced;
    endfunction

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Input transfers, output transfers, prediction and watchdog
    always @(posedge i_clk) begin
        in_xfer  = i_rst_n && i_in_valid && o_in_ready;
        out_xfer = i_rst_n && o_out_valid && i_out_ready;
        if (!i_rst_n) begin
            rx_phase  = PH_HEAD1;
            big_len   = 1'b0;
            cur_id    = '0;
            first_len = '0;
            len_seen  = 1'b0;
            pay_len   = '0;
            pay_cnt   = '0;
            lim_id    = ID_LIMIT_RESET;
            lim_len   = MAX_PAYLOAD_RESET;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_ID_LIMIT) lim_id = i_cfg_wdata[7:0];
                else if (i_cfg_addr == CFG_MAX_PAYLOAD) lim_len = i_cfg_wdata[15:0];
            end
            if (out_xfer) begin
                got_r = {o_kind, o_frame_id, o_frame_length, o_byte_index, o_data_byte, o_last};
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got_r);
                    error_count++;
                end else begin
                    want_r = pending_results.pop_front();
                    check_field("kind", 32'(want_r.kind), 32'(got_r.kind));
                    check_field("frame_id", 32'(want_r.frame_id), 32'(got_r.frame_id));
                    check_field("frame_length", 32'(want_r.frame_length),
                                32'(got_r.frame_length));
                    check_field("byte_index", 32'(want_r.byte_index), 32'(got_r.byte_index));
                    check_field("data_byte", 32'(want_r.data_byte), 32'(got_r.data_byte));
                    check_field("last", 32'(want_r.last), 32'(got_r.last));
                end
            end
            if (in_xfer) begin
                accepted_bytes++;
                if (parse_rx_byte(i_rx_byte, new_r)) pending_results.push_back(new_r);
            end
            if (in_xfer || out_xfer || i_cfg_we) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Byte driver: holds each byte until its transfer, then waits out a gap
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_xfer) begin
            i_in_valid <= 1'b1;
        end else if (send_gap > 0) begin
            send_gap   = send_gap - 1;
            i_in_valid <= 1'b0;
        end else if (rx_pending.size() > 0) begin
            i_rx_byte  <= rx_pending.pop_front();
            i_in_valid <= 1'b1;
            send_gap   = steady_flow ? 0 : pick_gap();
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Result receiver with random stalls
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (!steady_flow && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    task automatic push_byte(input logic [7:0] b);
        rx_pending.push_back(b);
        queued_bytes++;
    endtask

    task automatic push_header(input logic [7:0] id);
        push_byte(HEAD_FIRST);
        push_byte(HEAD_SECOND);
        push_byte(id);
    endtask

    task automatic push_length(input logic [15:0] len);
        if (gen_big) begin
            push_byte(len[15:8]);
            push_byte(len[7:0]);
        end else begin
            push_byte(len[7:0]);
            push_byte(len[15:8]);
        end
    endtask

    // Sender pauses here until every expected result has come
    task automatic wait_drained();
        while (accepted_bytes != queued_bytes || pending_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic program_regs(input logic [15:0] lim_data, input logic [15:0] max_data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_ID_LIMIT;
        i_cfg_wdata <= lim_data;
        @(negedge i_clk);
        i_cfg_addr  <= CFG_MAX_PAYLOAD;
        i_cfg_wdata <= max_data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        gen_id_limit = 32'(lim_data[7:0]);
        gen_max_len  = 32'(max_data);
    endtask

    // Mostly small lengths; some zero, some at the smaller of the limit and 40, some over the limit
    function automatic int unsigned pick_length();
        int unsigned r, len;
        r = $urandom_range(0, 99);
        if (r < 12 && gen_max_len < 65535) return $urandom_range(65535, gen_max_len + 1);
        if (r < 22) len = 0;
        else if (r < 30) len = (gen_max_len <= 40) ? gen_max_len : 40;
        else if (r < 82) len = $urandom_range(1, 6);
        else len = $urandom_range(7, 40);
        if (len > gen_max_len) len = gen_max_len;
        return len;
    endfunction

    // Random traffic: mostly well-formed frames, the rest selectors and junk
    task automatic gen_traffic(input int unsigned n_bytes);
        int unsigned start, r, len, k;
        logic [7:0] id;
        start = queued_bytes;
        while (queued_bytes - start < n_bytes) begin
            r = $urandom_range(0, 99);
            if (r < 62) begin
                if (gen_id_limit == 0) id = 8'($urandom_range(0, 253));
                else id = 8'($urandom_range(0, gen_id_limit - 1));
                len = pick_length();
                push_header(id);
                push_length(16'(len));
                if (len <= gen_max_len)
                    for (k = 0; k < len; k++) push_byte(8'($urandom_range(0, 255)));
            end else if (r < 72) begin
                gen_big = 1'($urandom_range(0, 1));
                push_header(gen_big ? ID_BIG_ENDIAN : ID_LITTLE_ENDIAN);
            end else if (r < 80) begin
                // id at or above the limit is dropped; with a limit above 253 id 253 is sent, which is accepted
                if (gen_id_limit <= 253) push_header(8'($urandom_range(gen_id_limit, 253)));
                else push_header(8'd253);
            end else if (r < 88) begin
                // broken header: second byte wrong
                id = 8'($urandom_range(0, 255));
                if (id == HEAD_SECOND) id = HEAD_FIRST;
                push_byte(HEAD_FIRST);
                push_byte(id);
            end else begin
                for (k = $urandom_range(1, 4); k > 0; k--)
                    push_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Stimulus sequence
    initial begin
        int unsigned lim_tab [NUM_PHASES];
        int unsigned max_tab [NUM_PHASES];
        int unsigned p;
        lim_tab = '{254, 0, 16, 1, 253, 0, 0, 0};
        max_tab = '{65535, 0, 1024, 3, 40, 0, 65535, 0};
        lim_tab[5] = $urandom_range(0, 254);
        max_tab[5] = $urandom_range(0, 64);
        lim_tab[6] = $urandom_range(0, 254);
        lim_tab[7] = $urandom_range(0, 254);
        max_tab[7] = $urandom_range(0, 65535);

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: big-endian select and frame, broken header, little-endian
        // select and frame, dropped id at the limit, zero length, length one past the max
        push_header(ID_BIG_ENDIAN);
        push_header(8'h03);
        push_byte(8'h00); push_byte(8'h02);
        push_byte(8'h11); push_byte(8'h22);
        push_byte(HEAD_FIRST); push_byte(HEAD_FIRST); push_byte(HEAD_SECOND);
        push_header(ID_LITTLE_ENDIAN);
        push_header(8'h01);
        push_byte(8'h02); push_byte(8'h00);
        push_byte(8'hA5); push_byte(8'h5A);
        push_header(ID_LIMIT_RESET);
        push_header(8'h00);
        push_byte(8'h00); push_byte(8'h00);
        push_header(ID_LIMIT_RESET - 8'd1);
        push_byte(8'h01); push_byte(8'h04);
        wait_drained();

        // Random phases, each under a new register setting
        for (p = 0; p < NUM_PHASES; p++) begin
            program_regs({8'($urandom_range(0, 255)), 8'(lim_tab[p])}, 16'(max_tab[p]));
            steady_flow = (p == 2);
            gen_traffic(PHASE_BYTES);
            wait_drained();
        end

        if (pending_results.size() != 0) begin
            $display("%0t: %0d results never arrived, expected 0, actual %0d",
                     $time, pending_results.size(), pending_results.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
